[src/long_press_gesture_detector_macros.svh]
// Assertion macros for the long-press gesture detector.
// No dependencies; included by the files that carry assertions.
`ifndef LONG_PRESS_GESTURE_DETECTOR_MACROS_SVH
`define LONG_PRESS_GESTURE_DETECTOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LPGD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LPGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpgd_pkg.sv]
// Package for the long-press gesture detector: sizes, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package lpgd_pkg;

    localparam int TOUCH_SLOTS  = 16;
    localparam int COORD_BITS   = 16;
    localparam int SLOT_BITS    = $clog2(TOUCH_SLOTS);
    localparam int CNT_BITS     = $clog2(TOUCH_SLOTS + 1);
    localparam int STORE_BITS   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SUM_BITS     = STORE_BITS + CNT_BITS;
    localparam int DIVC_BITS    = $clog2(SUM_BITS + 1);
    localparam int DIFF_BITS    = STORE_BITS + 1;
    localparam int MUL_BITS     = (DIFF_BITS > 13) ? DIFF_BITS : 13;
    localparam int PROD_BITS    = 2 * MUL_BITS;

    localparam logic [1:0] MODE_CLEAR    = 2'd0;
    localparam logic [1:0] MODE_TOUCHED  = 2'd1;
    localparam logic [1:0] MODE_FAILED   = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    localparam logic [1:0] GS_POSSIBLE  = 2'd0;
    localparam logic [1:0] GS_STARTED   = 2'd1;
    localparam logic [1:0] GS_CANCELLED = 2'd2;
    localparam logic [1:0] GS_FINISHED  = 2'd3;

    localparam logic [2:0] PST_DOWN        = 3'd0;
    localparam logic [2:0] PST_UP          = 3'd1;
    localparam logic [2:0] PST_MOTION      = 3'd2;
    localparam logic [2:0] PST_INTERRUPTED = 3'd5;

    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] MUL_X   = 2'd0;
    localparam logic [1:0] MUL_Y   = 2'd1;
    localparam logic [1:0] MUL_LIM = 2'd2;

    localparam logic [7:0] CFG_MIN_TOUCHES     = 8'd0;
    localparam logic [7:0] CFG_MAX_TOUCHES     = 8'd1;
    localparam logic [7:0] CFG_MOTION_LIMIT    = 8'd2;
    localparam logic [7:0] CFG_LONG_PRESS_TIME = 8'd3;

    localparam logic [4:0]  RST_MIN_TOUCHES     = 5'd1;
    localparam logic [4:0]  RST_MAX_TOUCHES     = 5'd1;
    localparam logic [11:0] RST_MOTION_LIMIT    = 12'd960;
    localparam logic [15:0] RST_LONG_PRESS_TIME = 16'd500;

    typedef struct packed {
        logic       load;
        logic       tick_update;
        logic       press_load;
        logic       clear_valids;
        logic       slot_write;
        logic       write_zero;
        logic       set_valid;
        logic       motion_latch;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       walk_start;
        logic       walk_step;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic [1:0] gs;
    } lpgd_cmd_t;

    typedef struct packed {
        logic op_tick;
        logic first;
        logic pst_down;
        logic pst_motion;
        logic lifted;
        logic count_one;
        logic count_gt_max;
        logic id_ok;
        logic tick_fire;
        logic slot_valid;
        logic motion_over;
        logic walk_done;
        logic n_lt_min;
        logic div_done;
        logic out_free;
    } lpgd_stat_t;

endpackage

[src/long_press_gesture_detector.sv]
// Top level of the long-press gesture detector. An input transaction is loaded and
// then decided, and a motion point adds a motion test; a report adds a slot walk,
// a check step, bit-serial centroid division and an output step, plus any wait while
// the result register stays full. One transaction is in work at a time. Synchronous
// active-low reset clears modes, timer and slot valid bits. Depends on lpgd_pkg,
// lpgd_ctrl, lpgd_dp and lpgd_ram.
`timescale 1ns / 1ps
module long_press_gesture_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic        s_first_of_event,
    input  logic [4:0]  s_point_count,
    input  logic [2:0]  s_point_state,
    input  logic [3:0]  s_touch_id,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [31:0] s_event_time,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_gesture_state,
    output logic [4:0]  m_touch_count,
    output logic [15:0] m_centroid_x,
    output logic [15:0] m_centroid_y,
    output logic [31:0] m_gesture_time
);
    import lpgd_pkg::*;

    lpgd_cmd_t  cmd;
    lpgd_stat_t stat;

    assign cfg_ready = 1'b1;

    lpgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    lpgd_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_operation      (s_operation),
        .s_first_of_event (s_first_of_event),
        .s_point_count    (s_point_count),
        .s_point_state    (s_point_state),
        .s_touch_id       (s_touch_id),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_event_time     (s_event_time),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_gesture_state  (m_gesture_state),
        .m_touch_count    (m_touch_count),
        .m_centroid_x     (m_centroid_x),
        .m_centroid_y     (m_centroid_y),
        .m_gesture_time   (m_gesture_time)
    );

endmodule

[src/lpgd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lpgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/lpgd_ctrl.sv]
// Controller of the long-press gesture detector: recognizer mode and the
// sequencer that steps the datapath. Depends on lpgd_pkg and the macro header.
`timescale 1ns / 1ps
`include "long_press_gesture_detector_macros.svh"
module lpgd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output lpgd_pkg::lpgd_cmd_t cmd,
    input  lpgd_pkg::lpgd_stat_t stat
);
    import lpgd_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_MRD    = 4'd2;
    localparam logic [3:0] ST_MSQX   = 4'd3;
    localparam logic [3:0] ST_MSQY   = 4'd4;
    localparam logic [3:0] ST_MLIM   = 4'd5;
    localparam logic [3:0] ST_MCMP   = 4'd6;
    localparam logic [3:0] ST_WALK   = 4'd7;
    localparam logic [3:0] ST_CHK    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       done_reg, done_next;
    logic       timer_reg, timer_next;
    logic [1:0] gs_reg, gs_next;
    logic       clr_reg, clr_next;
    logic       done_eff;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_CLEAR;
            done_reg  <= 1'b0;
            timer_reg <= 1'b0;
            gs_reg    <= GS_POSSIBLE;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
            timer_reg <= timer_next;
            gs_reg    <= gs_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        done_next  = done_reg;
        timer_next = timer_reg;
        gs_next    = gs_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        cmd.gs     = gs_reg;
        done_eff   = stat.first ? 1'b0 : done_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                if (stat.op_tick) begin
                    if (timer_reg) begin
                        cmd.tick_update = 1'b1;
                        if (stat.tick_fire) begin
                            timer_next     = 1'b0;
                            mode_next      = MODE_FINISHED;
                            gs_next        = GS_STARTED;
                            clr_next       = 1'b0;
                            cmd.walk_start = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                end else begin
                    done_next = done_eff;
                    case (mode_reg)
                        MODE_CLEAR: begin
                            if (stat.first && stat.pst_down) begin
                                cmd.clear_valids = 1'b1;
                                cmd.slot_write   = 1'b1;
                                cmd.set_valid    = 1'b1;
                                cmd.press_load   = 1'b1;
                                timer_next       = 1'b1;
                                mode_next        = MODE_TOUCHED;
                                done_next        = 1'b1;
                                gs_next          = GS_POSSIBLE;
                                clr_next         = 1'b0;
                                cmd.walk_start   = 1'b1;
                                state_next       = ST_WALK;
                            end
                        end
                        MODE_TOUCHED: begin
                            if (!done_eff) begin
                                if (stat.first && stat.count_gt_max) begin
                                    gs_next        = GS_CANCELLED;
                                    clr_next       = 1'b1;
                                    timer_next     = 1'b0;
                                    mode_next      = MODE_FAILED;
                                    done_next      = 1'b1;
                                    cmd.walk_start = 1'b1;
                                    state_next     = ST_WALK;
                                end else if (stat.pst_down) begin
                                    cmd.slot_write = 1'b1;
                                    cmd.set_valid  = 1'b1;
                                end else if (stat.lifted) begin
                                    gs_next        = GS_CANCELLED;
                                    clr_next       = 1'b1;
                                    timer_next     = 1'b0;
                                    mode_next      = stat.count_one ? MODE_CLEAR : MODE_FAILED;
                                    done_next      = 1'b1;
                                    cmd.walk_start = 1'b1;
                                    state_next     = ST_WALK;
                                end else if (stat.pst_motion && stat.id_ok) begin
                                    state_next = ST_MRD;
                                end
                            end
                        end
                        default: begin
                            if (stat.first) begin
                                done_next = 1'b1;
                                if (stat.count_one && stat.lifted) begin
                                    mode_next = MODE_CLEAR;
                                    if (mode_reg == MODE_FINISHED) begin
                                        gs_next        = GS_FINISHED;
                                        clr_next       = 1'b1;
                                        cmd.walk_start = 1'b1;
                                        state_next     = ST_WALK;
                                    end else begin
                                        cmd.clear_valids = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_MRD: begin
                cmd.motion_latch = 1'b1;
                if (!stat.slot_valid) begin
                    cmd.slot_write = 1'b1;
                    cmd.write_zero = 1'b1;
                    cmd.set_valid  = 1'b1;
                end
                state_next = ST_MSQX;
            end
            ST_MSQX: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_X;
                state_next   = ST_MSQY;
            end
            ST_MSQY: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_Y;
                state_next   = ST_MLIM;
            end
            ST_MLIM: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = MUL_LIM;
                state_next   = ST_MCMP;
            end
            ST_MCMP: begin
                state_next = ST_IDLE;
                if (stat.motion_over) begin
                    gs_next        = GS_CANCELLED;
                    clr_next       = 1'b0;
                    timer_next     = 1'b0;
                    mode_next      = MODE_FAILED;
                    done_next      = 1'b1;
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if ((gs_reg == GS_STARTED || gs_reg == GS_FINISHED) && stat.n_lt_min) begin
                    cmd.clear_valids = clr_reg;
                    state_next       = ST_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.clear_valids = clr_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LPGD_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, stat.out_free, "result overwritten")
    `LPGD_ASSERT_IMPL(a_finished_timer_off, mode_reg == MODE_FINISHED, !timer_reg,
        "timer running in finished mode")
    `LPGD_ASSERT_IMPL(a_clear_timer_off, mode_reg == MODE_CLEAR, !timer_reg,
        "timer running in clear mode")
    `LPGD_ASSERT_NEXT(a_motion_exit, state_reg == ST_MCMP,
        state_reg == ST_IDLE || state_reg == ST_WALK, "bad exit from motion test")

endmodule

[src/lpgd_dp.sv]
// Datapath of the long-press gesture detector: item and config registers,
// slot store, motion test, centroid walk and divider, result register.
// Depends on lpgd_pkg and lpgd_ram.
`timescale 1ns / 1ps
module lpgd_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpgd_pkg::lpgd_cmd_t  cmd,
    output lpgd_pkg::lpgd_stat_t stat,
    input  logic                 s_operation,
    input  logic                 s_first_of_event,
    input  logic [4:0]           s_point_count,
    input  logic [2:0]           s_point_state,
    input  logic [3:0]           s_touch_id,
    input  logic [15:0]          s_pos_x,
    input  logic [15:0]          s_pos_y,
    input  logic [31:0]          s_event_time,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_gesture_state,
    output logic [4:0]           m_touch_count,
    output logic [15:0]          m_centroid_x,
    output logic [15:0]          m_centroid_y,
    output logic [31:0]          m_gesture_time
);
    import lpgd_pkg::*;

    logic [4:0]  min_reg, max_reg;
    logic [11:0] lim_reg;
    logic [15:0] lpt_reg;

    logic                  op_reg, first_reg;
    logic [4:0]            count_reg;
    logic [2:0]            pst_reg;
    logic [3:0]            id_reg;
    logic [STORE_BITS-1:0] px_reg, py_reg;
    logic [31:0]           etime_reg;

    logic [31:0]            press_reg;
    logic [15:0]            elapsed_reg;
    logic [15:0]            elapsed_inc;
    logic [TOUCH_SLOTS-1:0] valid_reg, valid_next, id_onehot;
    logic [SLOT_BITS-1:0]   idx, raddr, walk_prev;
    logic                   id_ok;

    logic                    ram_we;
    logic [2*STORE_BITS-1:0] ram_wdata, ram_rdata;
    logic [STORE_BITS-1:0]   rd_x, rd_y;

    logic [STORE_BITS-1:0]        cur_x_reg, cur_y_reg;
    logic signed [DIFF_BITS-1:0]  dx, dy;
    logic signed [MUL_BITS-1:0]   mul_a;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic [PROD_BITS:0]           acc_reg;

    logic [CNT_BITS-1:0] walk_cnt_reg;
    logic [CNT_BITS-1:0] n_reg;
    logic [SUM_BITS-1:0] sum_x_reg, sum_y_reg;
    logic                walk_take;

    logic [SUM_BITS-1:0]  qx_reg, qy_reg;
    logic [CNT_BITS-1:0]  rx_reg, ry_reg;
    logic [DIVC_BITS-1:0] div_cnt_reg;
    logic [CNT_BITS:0]    tx, ty, n_ext;

    logic        m_valid_reg;
    logic [1:0]  gs_out_reg;
    logic [4:0]  cnt_out_reg;
    logic [15:0] cx_out_reg, cy_out_reg;
    logic [31:0] time_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= RST_MIN_TOUCHES;
            max_reg <= RST_MAX_TOUCHES;
            lim_reg <= RST_MOTION_LIMIT;
            lpt_reg <= RST_LONG_PRESS_TIME;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_TOUCHES:     min_reg <= cfg_data[4:0];
                CFG_MAX_TOUCHES:     max_reg <= cfg_data[4:0];
                CFG_MOTION_LIMIT:    lim_reg <= cfg_data[11:0];
                CFG_LONG_PRESS_TIME: lpt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            first_reg <= s_first_of_event;
            count_reg <= s_point_count;
            pst_reg   <= s_point_state;
            id_reg    <= s_touch_id;
            px_reg    <= STORE_BITS'(s_pos_x);
            py_reg    <= STORE_BITS'(s_pos_y);
            etime_reg <= s_event_time;
        end
    end

    assign id_ok       = (32'(id_reg) < TOUCH_SLOTS);
    assign idx         = SLOT_BITS'(id_reg);
    assign id_onehot   = TOUCH_SLOTS'(1) << idx;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg   <= '0;
            elapsed_reg <= '0;
            valid_reg   <= '0;
        end else begin
            if (cmd.press_load) begin
                press_reg   <= etime_reg;
                elapsed_reg <= '0;
            end else if (cmd.tick_update) begin
                elapsed_reg <= elapsed_inc;
            end
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        valid_next = cmd.clear_valids ? '0 : valid_reg;
        if (cmd.set_valid && id_ok) begin
            valid_next = valid_next | id_onehot;
        end
    end

    assign ram_we    = cmd.slot_write && id_ok;
    assign ram_wdata = cmd.write_zero ? '0 : {px_reg, py_reg};
    assign raddr     = cmd.walk_step ? SLOT_BITS'(walk_cnt_reg) : idx;
    assign rd_x      = ram_rdata[2*STORE_BITS-1:STORE_BITS];
    assign rd_y      = ram_rdata[STORE_BITS-1:0];

    lpgd_ram #(
        .WIDTH (2 * STORE_BITS),
        .DEPTH (TOUCH_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign dx = $signed({1'b0, cur_x_reg}) - $signed({1'b0, px_reg});
    assign dy = $signed({1'b0, cur_y_reg}) - $signed({1'b0, py_reg});

    always_comb begin
        case (cmd.mul_sel)
            MUL_X:   mul_a = MUL_BITS'(dx);
            MUL_Y:   mul_a = MUL_BITS'(dy);
            default: mul_a = MUL_BITS'($signed({1'b0, lim_reg}));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.motion_latch) begin
            cur_x_reg <= valid_reg[idx] ? rd_x : '0;
            cur_y_reg <= valid_reg[idx] ? rd_y : '0;
        end
        if (cmd.mul_step) begin
            prod_reg <= mul_a * mul_a;
            if (cmd.mul_sel == MUL_Y) begin
                acc_reg <= {1'b0, prod_reg};
            end else if (cmd.mul_sel == MUL_LIM) begin
                acc_reg <= acc_reg + {1'b0, prod_reg};
            end
        end
    end

    assign walk_prev = SLOT_BITS'(walk_cnt_reg - CNT_BITS'(1));
    assign walk_take = (walk_cnt_reg != '0) && valid_reg[walk_prev];

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            walk_cnt_reg <= '0;
            n_reg        <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
        end else if (cmd.walk_step) begin
            walk_cnt_reg <= walk_cnt_reg + CNT_BITS'(1);
            if (walk_take) begin
                n_reg     <= n_reg + CNT_BITS'(1);
                sum_x_reg <= sum_x_reg + SUM_BITS'(rd_x);
                sum_y_reg <= sum_y_reg + SUM_BITS'(rd_y);
            end
        end
    end

    assign n_ext = {1'b0, n_reg};
    assign tx    = {rx_reg, qx_reg[SUM_BITS-1]};
    assign ty    = {ry_reg, qy_reg[SUM_BITS-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qx_reg      <= sum_x_reg;
            qy_reg      <= sum_y_reg;
            rx_reg      <= '0;
            ry_reg      <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIVC_BITS'(1);
            if (tx >= n_ext) begin
                rx_reg <= CNT_BITS'(tx - n_ext);
                qx_reg <= {qx_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                rx_reg <= CNT_BITS'(tx);
                qx_reg <= {qx_reg[SUM_BITS-2:0], 1'b0};
            end
            if (ty >= n_ext) begin
                ry_reg <= CNT_BITS'(ty - n_ext);
                qy_reg <= {qy_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                ry_reg <= CNT_BITS'(ty);
                qy_reg <= {qy_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            gs_out_reg   <= cmd.gs;
            cnt_out_reg  <= 5'(n_reg);
            cx_out_reg   <= (n_reg == '0) ? 16'd0 : 16'(qx_reg);
            cy_out_reg   <= (n_reg == '0) ? 16'd0 : 16'(qy_reg);
            time_out_reg <= press_reg + ((cmd.gs != GS_POSSIBLE) ? {16'd0, lpt_reg} : 32'd0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_gesture_state = gs_out_reg;
    assign m_touch_count   = cnt_out_reg;
    assign m_centroid_x    = cx_out_reg;
    assign m_centroid_y    = cy_out_reg;
    assign m_gesture_time  = time_out_reg;

    always_comb begin
        stat              = '0;
        stat.op_tick      = (op_reg == OP_TICK);
        stat.first        = first_reg;
        stat.pst_down     = (pst_reg == PST_DOWN);
        stat.pst_motion   = (pst_reg == PST_MOTION);
        stat.lifted       = (pst_reg inside {PST_UP, PST_INTERRUPTED});
        stat.count_one    = (count_reg == 5'd1);
        stat.count_gt_max = (count_reg > max_reg);
        stat.id_ok        = id_ok;
        stat.tick_fire    = !(elapsed_inc < lpt_reg);
        stat.slot_valid   = valid_reg[idx];
        stat.motion_over  = (acc_reg > {1'b0, prod_reg});
        stat.walk_done    = (32'(walk_cnt_reg) == TOUCH_SLOTS);
        stat.n_lt_min     = ({1'b0, n_reg} < (CNT_BITS + 1)'(min_reg));
        stat.div_done     = (32'(div_cnt_reg) == SUM_BITS);
        stat.out_free     = !m_valid_reg || m_ready;
    end

endmodule

[tb/sv/long_press_gesture_detector_checker.sv]
// Checker for the long-press gesture detector: watches the input, register and
// result channels, predicts every report and compares it field by field.
// Depends on lpgd_pkg.
`timescale 1ns / 1ps
module long_press_gesture_detector_checker
    import lpgd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_operation,
    input  logic        s_first_of_event,
    input  logic [4:0]  s_point_count,
    input  logic [2:0]  s_point_state,
    input  logic [3:0]  s_touch_id,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [31:0] s_event_time,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_gesture_state,
    input  logic [4:0]  m_touch_count,
    input  logic [15:0] m_centroid_x,
    input  logic [15:0] m_centroid_y,
    input  logic [31:0] m_gesture_time,
    output int          mismatch_count,
    output int          reports_waiting,
    output int          reports_seen
);

    typedef struct packed {
        logic [1:0]  gs;
        logic [4:0]  touches;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [31:0] gtime;
    } gesture_report_t;

    gesture_report_t expected_reports[$];

    logic [4:0]  min_touches;
    logic [4:0]  max_touches;
    logic [11:0] motion_limit;
    logic [15:0] press_hold_ms;

    logic [1:0]  mode;
    logic        event_done;
    logic        slot_valid[TOUCH_SLOTS];
    logic [15:0] slot_x[TOUCH_SLOTS];
    logic [15:0] slot_y[TOUCH_SLOTS];
    logic [31:0] press_time;
    logic        timer_running;
    logic [15:0] elapsed_ms;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic clear_slots();
        for (int i = 0; i < TOUCH_SLOTS; i++) slot_valid[i] = 1'b0;
    endtask

    task automatic queue_report(input logic [1:0] gs);
        int          n;
        logic [31:0] sx;
        logic [31:0] sy;
        gesture_report_t r;
        n = 0;
        sx = 0;
        sy = 0;
        for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (slot_valid[i]) begin
                n++;
                sx += slot_x[i];
                sy += slot_y[i];
            end
        end
        if ((gs == GS_STARTED || gs == GS_FINISHED) && n < min_touches) return;
        r.gs = gs;
        r.touches = n[4:0];
        r.cx = (n != 0) ? 16'(sx / n) : 16'd0;
        r.cy = (n != 0) ? 16'(sy / n) : 16'd0;
        r.gtime = (gs == GS_POSSIBLE) ? press_time : press_time + press_hold_ms;
        expected_reports.push_back(r);
    endtask

    task automatic predict_transaction();
        logic   lifted;
        longint dx;
        longint dy;
        int     id;
        id = s_touch_id;
        lifted = (s_point_state == PST_UP) || (s_point_state == PST_INTERRUPTED);
        if (s_operation == OP_TICK) begin
            if (!timer_running) return;
            if (elapsed_ms < 16'hFFFF) elapsed_ms++;
            if (elapsed_ms < press_hold_ms) return;
            timer_running = 1'b0;
            mode = MODE_FINISHED;
            queue_report(GS_STARTED);
            return;
        end
        if (s_first_of_event) event_done = 1'b0;
        case (mode)
            MODE_CLEAR: begin
                if (!s_first_of_event || s_point_state != PST_DOWN) return;
                clear_slots();
                slot_valid[id] = 1'b1;
                slot_x[id] = s_pos_x;
                slot_y[id] = s_pos_y;
                press_time = s_event_time;
                elapsed_ms = 0;
                timer_running = 1'b1;
                mode = MODE_TOUCHED;
                event_done = 1'b1;
                queue_report(GS_POSSIBLE);
            end
            MODE_FAILED, MODE_FINISHED: begin
                if (!s_first_of_event) return;
                event_done = 1'b1;
                if (s_point_count == 5'd1 && lifted) begin
                    if (mode == MODE_FINISHED) queue_report(GS_FINISHED);
                    clear_slots();
                    mode = MODE_CLEAR;
                end
            end
            default: begin
                if (event_done) return;
                if (s_first_of_event && s_point_count > max_touches) begin
                    queue_report(GS_CANCELLED);
                    clear_slots();
                    timer_running = 1'b0;
                    mode = MODE_FAILED;
                    event_done = 1'b1;
                end else if (s_point_state == PST_DOWN) begin
                    slot_valid[id] = 1'b1;
                    slot_x[id] = s_pos_x;
                    slot_y[id] = s_pos_y;
                end else if (lifted) begin
                    queue_report(GS_CANCELLED);
                    clear_slots();
                    timer_running = 1'b0;
                    mode = (s_point_count == 5'd1) ? MODE_CLEAR : MODE_FAILED;
                    event_done = 1'b1;
                end else if (s_point_state == PST_MOTION) begin
                    if (!slot_valid[id]) begin
                        slot_valid[id] = 1'b1;
                        slot_x[id] = 0;
                        slot_y[id] = 0;
                    end
                    dx = longint'(slot_x[id]) - longint'(s_pos_x);
                    dy = longint'(slot_y[id]) - longint'(s_pos_y);
                    if (dx * dx + dy * dy > longint'(motion_limit) * longint'(motion_limit)) begin
                        queue_report(GS_CANCELLED);
                        timer_running = 1'b0;
                        mode = MODE_FAILED;
                        event_done = 1'b1;
                    end
                end
            end
        endcase
    endtask

    task automatic compare_report();
        gesture_report_t want;
        reports_seen++;
        if (expected_reports.size() == 0) begin
            report_mismatch("unexpected report, state", m_gesture_state, -1);
            return;
        end
        want = expected_reports.pop_front();
        if (m_gesture_state != want.gs)
            report_mismatch("gesture_state", m_gesture_state, want.gs);
        if (m_touch_count != want.touches)
            report_mismatch("touch_count", m_touch_count, want.touches);
        if (m_centroid_x != want.cx) report_mismatch("centroid_x", m_centroid_x, want.cx);
        if (m_centroid_y != want.cy) report_mismatch("centroid_y", m_centroid_y, want.cy);
        if (m_gesture_time != want.gtime)
            report_mismatch("gesture_time", m_gesture_time, want.gtime);
    endtask

    initial begin
        mismatch_count = 0;
        reports_seen = 0;
        reports_waiting = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            min_touches = RST_MIN_TOUCHES;
            max_touches = RST_MAX_TOUCHES;
            motion_limit = RST_MOTION_LIMIT;
            press_hold_ms = RST_LONG_PRESS_TIME;
            mode = MODE_CLEAR;
            event_done = 1'b0;
            clear_slots();
            for (int i = 0; i < TOUCH_SLOTS; i++) begin
                slot_x[i] = 0;
                slot_y[i] = 0;
            end
            press_time = 0;
            timer_running = 1'b0;
            elapsed_ms = 0;
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_TOUCHES:     min_touches = cfg_data[4:0];
                    CFG_MAX_TOUCHES:     max_touches = cfg_data[4:0];
                    CFG_MOTION_LIMIT:    motion_limit = cfg_data[11:0];
                    CFG_LONG_PRESS_TIME: press_hold_ms = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_transaction();
            if (m_valid && m_ready) compare_report();
        end
        reports_waiting <= expected_reports.size();
    end

    final begin
        if (expected_reports.size() != 0)
            $display("%0d reports never arrived", expected_reports.size());
    end

endmodule

[tb/sv/long_press_gesture_detector_test.sv]
// Top of the long-press gesture detector testbench: clock, reset, stimulus,
// result-side back-pressure and the verdict. Depends on lpgd_pkg,
// long_press_gesture_detector and long_press_gesture_detector_checker.
`timescale 1ns / 1ps
module long_press_gesture_detector_test;
    import lpgd_pkg::*;

    localparam logic [2:0] PST_LEAVE      = 3'd3;
    localparam logic [2:0] PST_STATIONARY = 3'd4;
    localparam logic       OP_POINT       = 1'b0;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic        s_first_of_event;
    logic [4:0]  s_point_count;
    logic [2:0]  s_point_state;
    logic [3:0]  s_touch_id;
    logic [15:0] s_pos_x;
    logic [15:0] s_pos_y;
    logic [31:0] s_event_time;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_gesture_state;
    logic [4:0]  m_touch_count;
    logic [15:0] m_centroid_x;
    logic [15:0] m_centroid_y;
    logic [31:0] m_gesture_time;

    int mismatch_count;
    int reports_waiting;
    int reports_seen;

    int          transactions_sent;
    int          settings_used;
    bit          sender_paced;
    int          receiver_hold;
    logic [31:0] now_ms;
    logic [11:0] cur_limit;
    logic [15:0] cur_press;
    logic [4:0]  cur_max;
    logic [15:0] held_x[16];
    logic [15:0] held_y[16];

    long_press_gesture_detector i_dut (.*);

    long_press_gesture_detector_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
    end

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("timeout with %0d reports outstanding", reports_waiting);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int gap;
        m_ready <= 1'b0;
        receiver_hold = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (receiver_hold > 0) begin
                gap = receiver_hold;
                receiver_hold = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_transaction(input logic op, input logic first, input logic [4:0] cnt,
                                    input logic [2:0] pst, input logic [3:0] id,
                                    input logic [15:0] x, input logic [15:0] y);
        int gap;
        gap = sender_paced ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        now_ms = now_ms + $urandom_range(0, 3);
        s_operation <= op;
        s_first_of_event <= first;
        s_point_count <= cnt;
        s_point_state <= pst;
        s_touch_id <= id;
        s_pos_x <= x;
        s_pos_y <= y;
        s_event_time <= ($urandom_range(0, 15) == 0) ? $urandom : now_ms;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        transactions_sent++;
    endtask

    task automatic send_tick();
        send_transaction(OP_TICK, 1'($urandom), 5'($urandom), 3'($urandom), 4'($urandom),
                         16'($urandom), 16'($urandom));
    endtask

    task automatic send_point(input logic first, input logic [4:0] cnt, input logic [2:0] pst,
                              input logic [3:0] id, input logic [15:0] x, input logic [15:0] y);
        send_transaction(OP_POINT, first, cnt, pst, id, x, y);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (reports_waiting != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [15:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [4:0] min_t, input logic [4:0] max_t,
                                 input logic [11:0] lim, input logic [15:0] press);
        wait_idle();
        write_register(CFG_MIN_TOUCHES, {11'd0, min_t});
        write_register(CFG_MAX_TOUCHES, {11'd0, max_t});
        write_register(CFG_MOTION_LIMIT, {4'd0, lim});
        write_register(CFG_LONG_PRESS_TIME, press);
        cur_max = max_t;
        cur_limit = lim;
        cur_press = press;
        settings_used++;
    endtask

    task automatic send_noise();
        send_transaction(1'($urandom), 1'($urandom), 5'($urandom), 3'($urandom),
                         4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_ticks();
        int budget;
        int n;
        budget = (cur_press > 40) ? 40 : cur_press + 3;
        n = $urandom_range(0, budget);
        repeat (n) send_tick();
    endtask

    task automatic send_motion_event(input int fingers, input logic [3:0] base);
        logic [3:0]  id;
        logic [2:0]  pst;
        logic [15:0] j;
        bit          far;
        for (int k = 0; k < fingers; k++) begin
            id = 4'(base + k);
            case ($urandom_range(0, 9))
                0: pst = PST_LEAVE;
                1: pst = 3'd6;
                2: pst = 3'd7;
                3, 4: pst = PST_STATIONARY;
                default: pst = PST_MOTION;
            endcase
            far = ($urandom_range(0, 11) == 0);
            j = cur_limit / 2;
            if (far) begin
                held_x[id] = 16'($urandom);
                held_y[id] = 16'($urandom);
            end else begin
                held_x[id] = 16'(held_x[id] + $urandom_range(0, j) - j / 2);
                held_y[id] = 16'(held_y[id] + $urandom_range(0, j) - j / 2);
            end
            send_point(k == 0, 5'(fingers), pst, id, held_x[id], held_y[id]);
        end
    endtask

    task automatic send_press();
        int         fingers;
        logic [3:0] base;
        logic [3:0] id;
        base = 4'($urandom);
        fingers = ($urandom_range(0, 7) == 0) ? cur_max + 1 : $urandom_range(1, cur_max);
        if (fingers > 16) fingers = 16;
        held_x[base] = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
        held_y[base] = ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom);
        send_point(1'b1, 5'd1, PST_DOWN, base, held_x[base], held_y[base]);
        if (fingers > 1) begin
            for (int k = 0; k < fingers; k++) begin
                id = 4'(base + k);
                if (k > 0) begin
                    held_x[id] = 16'(held_x[base] + $urandom_range(0, 255));
                    held_y[id] = 16'(held_y[base] + $urandom_range(0, 255));
                end
                send_point(k == 0, 5'(fingers), PST_DOWN, id, held_x[id], held_y[id]);
            end
        end
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) == 0) send_ticks();
            else send_motion_event(fingers, base);
            if ($urandom_range(0, 19) == 0) send_noise();
        end
        send_ticks();
        send_point(1'b1, 5'd1, ($urandom_range(0, 1) == 0) ? PST_UP : PST_INTERRUPTED, base,
                   held_x[base], held_y[base]);
    endtask

    task automatic run_directed();
        send_tick();
        send_point(1'b1, 5'd1, PST_UP, 4'd0, 16'd0, 16'd0);
        send_point(1'b0, 5'd1, PST_DOWN, 4'd1, 16'd5, 16'd5);
        now_ms = 32'hFFFF_FF00;
        send_point(1'b1, 5'd1, PST_DOWN, 4'd15, 16'hFFFF, 16'hFFFF);
        send_point(1'b0, 5'd2, PST_DOWN, 4'd3, 16'd7, 16'd7);
        send_point(1'b1, 5'd1, 3'd6, 4'd15, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, 3'd7, 4'd15, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_LEAVE, 4'd15, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_STATIONARY, 4'd15, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_MOTION, 4'd15, 16'hFFFF, 16'hFFFF);
        send_point(1'b1, 5'd1, PST_MOTION, 4'd15, 16'hFFFF - 16'd960, 16'hFFFF);
        send_point(1'b1, 5'd1, PST_MOTION, 4'd2, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_MOTION, 4'd15, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_DOWN, 4'd0, 16'd0, 16'd0);
        send_point(1'b1, 5'd2, PST_UP, 4'd0, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_INTERRUPTED, 4'd0, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_DOWN, 4'd0, 16'd0, 16'd0);
        send_point(1'b1, 5'd31, PST_DOWN, 4'd1, 16'd1, 16'd1);
        send_point(1'b1, 5'd1, PST_UP, 4'd0, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_DOWN, 4'd7, 16'h8000, 16'h7FFF);
        send_point(1'b1, 5'd2, PST_UP, 4'd7, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_UP, 4'd7, 16'd0, 16'd0);
        send_point(1'b1, 5'd1, PST_DOWN, 4'd1, 16'd9, 16'd9);
        send_point(1'b1, 5'd1, PST_INTERRUPTED, 4'd1, 16'd9, 16'd9);
    endtask

    initial begin
        logic [4:0]  mins[7]   = '{5'd1, 5'd16, 5'd2, 5'd1, 5'd3, 5'd1, 5'd4};
        logic [4:0]  maxs[7]   = '{5'd1, 5'd16, 5'd4, 5'd16, 5'd8, 5'd2, 5'd16};
        logic [11:0] limits[7] = '{12'd960, 12'd4095, 12'd100, 12'd0, 12'd2000, 12'd960, 12'd50};
        logic [15:0] presses[7] = '{16'd3, 16'd1, 16'd7, 16'd0, 16'd65535, 16'd12, 16'd5};
        int target;
        s_valid <= 1'b0;
        s_operation <= 1'b0;
        s_first_of_event <= 1'b0;
        s_point_count <= 5'd1;
        s_point_state <= PST_DOWN;
        s_touch_id <= 4'd0;
        s_pos_x <= 16'd0;
        s_pos_y <= 16'd0;
        s_event_time <= 32'd0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MIN_TOUCHES;
        cfg_data <= 16'd0;
        aresetn <= 1'b0;
        transactions_sent = 0;
        settings_used = 0;
        now_ms = 0;
        cur_max = RST_MAX_TOUCHES;
        cur_limit = RST_MOTION_LIMIT;
        cur_press = RST_LONG_PRESS_TIME;
        for (int i = 0; i < 16; i++) begin
            held_x[i] = 0;
            held_y[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_paced = 1'b1;
        run_directed();
        for (int p = 0; p < 7; p++) begin
            apply_setting(mins[p], maxs[p], limits[p], presses[p]);
            sender_paced = $urandom_range(0, 2) != 0;
            if (p == 2) receiver_hold = 500;
            target = transactions_sent + 175;
            while (transactions_sent < target) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else send_press();
            end
        end
        wait_idle();
        $display("%0d input transactions over %0d register settings, %0d reports checked",
                 transactions_sent, settings_used, reports_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
